// File: hw/rtl/sba_pkg.sv
package sba_pkg;

  // Field widths fixed by the interface
  localparam int RADIUS_W = 10;
  localparam int HARD_W   = 17;
  localparam int COORD_W  = 10;
  localparam int ALPHA_W  = 8;

  // Coordinate compare width: holds 2R for any radius the port can carry
  localparam int CMP_W = COORD_W + 1;

  localparam int MAX_RADIUS_DEF = 512;

  localparam logic [HARD_W-1:0]  HARD_ONE   = 17'h10000;
  localparam logic [ALPHA_W-1:0] FULL_ALPHA = 8'hFF;

  // Fraction bits of the distance, and of its square fed to the root
  localparam int DIST_FRAC = 8;
  localparam int SQ_FRAC   = 2 * DIST_FRAC;

  // Configuration register map
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = HARD_W;

  localparam logic [CFG_IDX_W-1:0] REG_BRUSH_RADIUS = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_HARDNESS     = 1'b1;

endpackage

// File: hw/rtl/soft_brush_alpha_mask.sv
// Soft brush alpha mask.
// Input channel (in_valid_i / in_stall_o) carries one pixel coordinate
// (x_pos_i, y_pos_i) of the 2R by 2R brush square per request. The output
// channel (out_valid_o / out_stall_i) returns that pixel's alpha_o, one per
// input, in order.
// The pipeline depth is set by the square root, which resolves one result bit
// per stage (RW + 9 stages, RW = min(10, clog2(MAX_RADIUS+1))), plus 8 stages
// of the falloff divider and 4 stages of distance and classification logic.
// Throughput is one pixel per cycle while the receiver does not stall.
// When the receiver stalls with a result waiting, the whole pipeline holds
// and in_stall_o rises; nothing is dropped or repeated.
// Configuration (cfg_valid_i / cfg_ready_o, always ready) writes brush_radius
// at index 0 and hardness at index 1; write only while no pixel is in flight.
// Reset clears both registers (radius 0: every pixel gives alpha 0) and
// empties the pipeline.
module soft_brush_alpha_mask #(
  parameter int MAX_RADIUS = sba_pkg::MAX_RADIUS_DEF
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           in_valid_i,
  output logic                           in_stall_o,
  input  logic [sba_pkg::COORD_W-1:0]    x_pos_i,
  input  logic [sba_pkg::COORD_W-1:0]    y_pos_i,
  output logic                           out_valid_o,
  input  logic                           out_stall_i,
  output logic [sba_pkg::ALPHA_W-1:0]    alpha_o,
  input  logic                           cfg_valid_i,
  output logic                           cfg_ready_o,
  input  logic [sba_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [sba_pkg::CFG_DATA_W-1:0] cfg_data_i
);

  localparam int RW_RAW = $clog2(MAX_RADIUS + 1);
  localparam int RW     = (RW_RAW > sba_pkg::RADIUS_W) ? sba_pkg::RADIUS_W : RW_RAW;
  localparam int CW     = sba_pkg::CMP_W;
  localparam int SQW    = 2 * RW;               // dx^2
  localparam int D2W    = 2 * RW + 1;           // dx^2 + dy^2
  localparam int K      = RW + 1 + sba_pkg::DIST_FRAC; // root bits (r8)
  localparam int VW     = 2 * K;                // radicand
  localparam int RMW    = K + 3;                // root remainder
  localparam int RLW    = RW + sba_pkg::DIST_FRAC;     // R << 8
  localparam int RHW    = RW + sba_pkg::HARD_W;        // R * h, divisor
  localparam int NW     = RW + 24;              // dividend
  localparam int QW     = sba_pkg::ALPHA_W;

  typedef struct packed {
    logic [VW-1:0]  rad;
    logic [RMW-1:0] rem;
    logic [K-1:0]   root;
    logic           ins;
  } sq_t;

  typedef struct packed {
    logic [NW-1:0] rem;
    logic [QW-1:0] quo;
    logic          div;
  } dv_t;

  // ---------------------------------------------------------------------------
  // Configuration, stored already clamped
  // ---------------------------------------------------------------------------
  logic [RW-1:0]                 rcl_q;
  logic [sba_pkg::HARD_W-1:0]    hcl_q;
  logic [RHW-1:0]                rh_q, den_q;
  logic [sba_pkg::RADIUS_W-1:0]  rad_w;
  logic [RW-1:0]                 rcl_d;
  logic [sba_pkg::HARD_W-1:0]    hcl_d;

  assign cfg_ready_o = 1'b1;
  assign rad_w       = cfg_data_i[sba_pkg::RADIUS_W-1:0];
  assign rcl_d = (int'(rad_w) > MAX_RADIUS) ? RW'(MAX_RADIUS) : RW'(rad_w);
  assign hcl_d = (cfg_data_i > sba_pkg::HARD_ONE) ? sba_pkg::HARD_ONE : cfg_data_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rcl_q <= '0;
      hcl_q <= '0;
      rh_q  <= '0;
      den_q <= '0;
    end else begin
      if (cfg_valid_i) begin
        unique case (cfg_index_i)
          sba_pkg::REG_BRUSH_RADIUS: rcl_q <= rcl_d;
          sba_pkg::REG_HARDNESS:     hcl_q <= hcl_d;
          default: ;
        endcase
      end
      // products are registered from the registers and follow them in the next cycle; no pixel needs them sooner
      rh_q  <= RHW'(rcl_q) * RHW'(hcl_q);
      den_q <= RHW'(rcl_q) * RHW'(sba_pkg::HARD_ONE - hcl_q);
    end
  end

  // ---------------------------------------------------------------------------
  // Pipeline control: one global enable
  // ---------------------------------------------------------------------------
  logic en;
  dv_t  dv_q [QW];
  logic dv_vld_q [QW];

  assign en          = !(dv_vld_q[QW-1] && out_stall_i);
  assign in_stall_o  = !en;
  assign out_valid_o = dv_vld_q[QW-1];
  assign alpha_o     = dv_q[QW-1].quo;

  // ---------------------------------------------------------------------------
  // Stage A: offsets from the center, square bounds
  // ---------------------------------------------------------------------------
  logic [CW-1:0] r_ext, two_r, x_ext, y_ext, dx_a, dy_a;
  logic          ins_a;
  logic [RW-1:0] a_dx_q, a_dy_q;
  logic          a_ins_q, a_vld_q;

  assign r_ext = CW'(rcl_q);
  assign two_r = r_ext << 1;
  assign x_ext = CW'(x_pos_i);
  assign y_ext = CW'(y_pos_i);
  assign dx_a  = (x_ext >= r_ext) ? (x_ext - r_ext) : (r_ext - x_ext);
  assign dy_a  = (y_ext >= r_ext) ? (y_ext - r_ext) : (r_ext - y_ext);
  assign ins_a = (rcl_q != '0) && (x_ext < two_r) && (y_ext < two_r);

  // ---------------------------------------------------------------------------
  // Stage B: squares. Stage C: sum.
  // ---------------------------------------------------------------------------
  logic [SQW-1:0] b_dx2_q, b_dy2_q;
  logic           b_ins_q, b_vld_q;
  logic [D2W-1:0] c_d2_q;
  logic           c_ins_q, c_vld_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_vld_q <= 1'b0;
      b_vld_q <= 1'b0;
      c_vld_q <= 1'b0;
    end else if (en) begin
      a_vld_q <= in_valid_i;
      b_vld_q <= a_vld_q;
      c_vld_q <= b_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      // inside the square dx, dy never exceed R
      a_dx_q  <= RW'(dx_a);
      a_dy_q  <= RW'(dy_a);
      a_ins_q <= ins_a;
      b_dx2_q <= SQW'(a_dx_q) * SQW'(a_dx_q);
      b_dy2_q <= SQW'(a_dy_q) * SQW'(a_dy_q);
      b_ins_q <= a_ins_q;
      c_d2_q  <= D2W'(b_dx2_q) + D2W'(b_dy2_q);
      c_ins_q <= b_ins_q;
    end
  end

  // ---------------------------------------------------------------------------
  // Square root, one result bit per stage: r8 = isqrt(d2 << 16)
  // ---------------------------------------------------------------------------
  sq_t  sq_q [K];
  logic sq_vld_q [K];

  for (genvar j = 0; j < K; j++) begin : g_sqrt
    sq_t           s_in, s_nx;
    logic          v_in;
    logic [RMW-1:0] tmp, trial;

    if (j == 0) begin : g_first
      assign s_in.rad  = VW'({c_d2_q, {sba_pkg::SQ_FRAC{1'b0}}});
      assign s_in.rem  = '0;
      assign s_in.root = '0;
      assign s_in.ins  = c_ins_q;
      assign v_in      = c_vld_q;
    end else begin : g_next
      assign s_in = sq_q[j-1];
      assign v_in = sq_vld_q[j-1];
    end

    assign tmp   = {s_in.rem[RMW-3:0], s_in.rad[VW-1 -: 2]};
    assign trial = RMW'({s_in.root, 2'b01});

    always_comb begin
      s_nx     = s_in;
      s_nx.rad = {s_in.rad[VW-3:0], 2'b00};
      if (tmp >= trial) begin
        s_nx.rem  = tmp - trial;
        s_nx.root = {s_in.root[K-2:0], 1'b1};
      end else begin
        s_nx.rem  = tmp;
        s_nx.root = {s_in.root[K-2:0], 1'b0};
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        sq_vld_q[j] <= 1'b0;
      end else if (en) begin
        sq_vld_q[j] <= v_in;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en) begin
        sq_q[j] <= s_nx;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Stage E: classify into outside, hard core or soft ring; build dividend
  // ---------------------------------------------------------------------------
  logic [K-1:0]   r8, rlim_k;
  logic [RLW-1:0] rlim, dist_in;
  logic [NW-1:0]  num;
  logic           in_disk, in_core;
  dv_t            e_d, e_q;
  logic           e_vld_q;

  assign r8      = sq_q[K-1].root;
  assign rlim    = RLW'(rcl_q) << sba_pkg::DIST_FRAC;
  assign rlim_k  = K'(rlim);
  assign in_disk = sq_q[K-1].ins && (r8 <= rlim_k);
  assign in_core = (RHW'(r8) << sba_pkg::DIST_FRAC) <= rh_q;
  assign dist_in = RLW'(rlim_k - r8);
  // 255 * (256R - r8) * 256
  assign num     = ((NW'(dist_in) << 8) - NW'(dist_in)) << 8;

  always_comb begin
    e_d.rem = num;
    e_d.quo = '0;
    e_d.div = 1'b0;
    priority if (!in_disk) begin
      e_d.quo = '0;
    end else if (in_core) begin
      e_d.quo = sba_pkg::FULL_ALPHA;
    end else begin
      e_d.div = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      e_vld_q <= 1'b0;
    end else if (en) begin
      e_vld_q <= sq_vld_q[K-1];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      e_q <= e_d;
    end
  end

  // ---------------------------------------------------------------------------
  // Restoring divider, one quotient bit per stage, MSB first.
  // In the soft ring the quotient is below 255, so 8 bits cover it.
  // ---------------------------------------------------------------------------
  for (genvar j = 0; j < QW; j++) begin : g_div
    dv_t           d_in, d_nx;
    logic          v_in;
    logic [NW-1:0] den_sh;

    if (j == 0) begin : g_first
      assign d_in = e_q;
      assign v_in = e_vld_q;
    end else begin : g_next
      assign d_in = dv_q[j-1];
      assign v_in = dv_vld_q[j-1];
    end

    assign den_sh = NW'(den_q) << (QW - 1 - j);

    always_comb begin
      d_nx = d_in;
      if (d_in.div && (d_in.rem >= den_sh)) begin
        d_nx.rem = d_in.rem - den_sh;
        d_nx.quo = d_in.quo | (QW'(1) << (QW - 1 - j));
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        dv_vld_q[j] <= 1'b0;
      end else if (en) begin
        dv_vld_q[j] <= v_in;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en) begin
        dv_q[j] <= d_nx;
      end
    end
  end

endmodule

// File: bench/soft_brush_alpha_mask_tb.sv
`timescale 1ns / 100ps

module soft_brush_alpha_mask_tb;

  localparam int TOTAL_PIXELS = 950;
  localparam int SETTLE_CYCLES = 40;  // pipeline is 31 deep at MAX_RADIUS 512
  localparam int MAX_IDLE = 18;

  typedef struct packed {
    logic [sba_pkg::COORD_W-1:0] x;
    logic [sba_pkg::COORD_W-1:0] y;
  } pixel_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid_i = 1'b0;
  logic in_stall_o;
  logic [sba_pkg::COORD_W-1:0] x_pos_i = '0;
  logic [sba_pkg::COORD_W-1:0] y_pos_i = '0;
  logic out_valid_o;
  logic out_stall_i = 1'b0;
  logic [sba_pkg::ALPHA_W-1:0] alpha_o;
  logic cfg_valid_i = 1'b0;
  logic cfg_ready_o;
  logic [sba_pkg::CFG_IDX_W-1:0] cfg_index_i = '0;
  logic [sba_pkg::CFG_DATA_W-1:0] cfg_data_i = '0;

  // brush setting as the block should hold it
  logic [sba_pkg::RADIUS_W-1:0] radius_cfg = '0;
  logic [sba_pkg::HARD_W-1:0] hard_cfg = '0;

  pixel_t pixel_q[$];
  logic [sba_pkg::ALPHA_W-1:0] alpha_q[$];
  bit pix_held = 1'b0;
  bit calm = 1'b0;
  int unsigned gap_left = 0;
  int unsigned stall_left = 0;
  int unsigned error_cnt = 0;
  int unsigned checked_cnt = 0;
  int unsigned queued_cnt = 0;
  int unsigned phase_cnt = 0;

  soft_brush_alpha_mask u_top (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .x_pos_i     (x_pos_i),
    .y_pos_i     (y_pos_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .alpha_o     (alpha_o),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i)
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    #5_000_000;
    $display("soft_brush_alpha_mask regression: fail");
    $finish;
  end

  function automatic int unsigned idle_draw();
    return calm ? 0 : $urandom_range(0, MAX_IDLE);
  endfunction

  // Distance is floor(sqrt(d2 * 2^16)), i.e. r with 8 fraction bits.
  function automatic logic [sba_pkg::ALPHA_W-1:0] predict_alpha(
    input logic [sba_pkg::COORD_W-1:0] xp,
    input logic [sba_pkg::COORD_W-1:0] yp
  );
    longint unsigned rad, hard, dx, dy, sq, root, probe, rlim, den, num, quot;
    rad = radius_cfg;
    hard = hard_cfg;
    if (rad > sba_pkg::MAX_RADIUS_DEF) rad = sba_pkg::MAX_RADIUS_DEF;
    if (hard > sba_pkg::HARD_ONE) hard = sba_pkg::HARD_ONE;
    if (rad == 0 || xp >= 2 * rad || yp >= 2 * rad) return '0;
    dx = (xp >= rad) ? xp - rad : rad - xp;
    dy = (yp >= rad) ? yp - rad : rad - yp;
    sq = (dx * dx + dy * dy) << sba_pkg::SQ_FRAC;
    root = 0;
    probe = 64'd1 << 62;
    while (probe > sq) probe >>= 2;
    while (probe != 0) begin
      if (sq >= root + probe) begin
        sq -= root + probe;
        root = (root >> 1) + probe;
      end else begin
        root >>= 1;
      end
      probe >>= 2;
    end
    rlim = rad << sba_pkg::DIST_FRAC;
    if (root > rlim) return '0;
    if ((root << sba_pkg::DIST_FRAC) <= rad * hard) return sba_pkg::FULL_ALPHA;
    den = rad * (sba_pkg::HARD_ONE - hard);
    if (den == 0) return sba_pkg::FULL_ALPHA;
    num = sba_pkg::FULL_ALPHA * (rlim - root) * 256;
    quot = num / den;
    return (quot > sba_pkg::FULL_ALPHA) ? sba_pkg::FULL_ALPHA : quot[sba_pkg::ALPHA_W-1:0];
  endfunction

  // request driver
  always @(negedge clk_i) begin
    if (rst_ni && !pix_held) begin
      if (gap_left != 0) begin
        gap_left--;
        in_valid_i <= 1'b0;
      end else if (pixel_q.size() != 0) begin
        pixel_t pix;
        pix = pixel_q.pop_front();
        pix_held = 1'b1;
        in_valid_i <= 1'b1;
        x_pos_i <= pix.x;
        y_pos_i <= pix.y;
        gap_left = idle_draw();
      end else begin
        in_valid_i <= 1'b0;
      end
    end
  end

  // receiver backpressure
  always @(negedge clk_i) begin
    out_stall_i <= (stall_left != 0);
    if (stall_left != 0) stall_left--;
  end

  // monitor: predict on input accept, check on output accept
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_valid_i && !in_stall_o) begin
        alpha_q.push_back(predict_alpha(x_pos_i, y_pos_i));
        pix_held = 1'b0;
      end
      if (out_valid_o && !out_stall_i) begin
        if (alpha_q.size() == 0) begin
          $error("alpha: unexpected result %0d, nothing expected", alpha_o);
          error_cnt++;
        end else begin
          logic [sba_pkg::ALPHA_W-1:0] want;
          want = alpha_q.pop_front();
          if (alpha_o !== want) begin
            $error("alpha mismatch: expected %0d, actual %0d", want, alpha_o);
            error_cnt++;
          end
          checked_cnt++;
        end
        stall_left = idle_draw();
      end
    end
  end

  task automatic write_reg(input logic [sba_pkg::CFG_IDX_W-1:0] idx,
                           input logic [sba_pkg::CFG_DATA_W-1:0] data);
    @(negedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
    if (idx == sba_pkg::REG_BRUSH_RADIUS) radius_cfg = data[sba_pkg::RADIUS_W-1:0];
    else hard_cfg = data[sba_pkg::HARD_W-1:0];
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  task automatic set_brush(input logic [sba_pkg::CFG_DATA_W-1:0] rad_data,
                           input logic [sba_pkg::CFG_DATA_W-1:0] hard_data);
    if ($urandom_range(0, 1)) begin
      write_reg(sba_pkg::REG_BRUSH_RADIUS, rad_data);
      write_reg(sba_pkg::REG_HARDNESS, hard_data);
    end else begin
      write_reg(sba_pkg::REG_HARDNESS, hard_data);
      write_reg(sba_pkg::REG_BRUSH_RADIUS, rad_data);
    end
    phase_cnt++;
  endtask

  task automatic queue_pixel(input int unsigned xp, input int unsigned yp);
    pixel_t pix;
    pix.x = xp[sba_pkg::COORD_W-1:0];
    pix.y = yp[sba_pkg::COORD_W-1:0];
    pixel_q.push_back(pix);
    queued_cnt++;
  endtask

  task automatic drain();
    do @(negedge clk_i); while (pixel_q.size() != 0 || pix_held || alpha_q.size() != 0);
    repeat (SETTLE_CYCLES) @(negedge clk_i);
  endtask

  initial begin
    int unsigned rad, reff, hard, npix;
    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // radius zero after reset: everything transparent
    queue_pixel(0, 0);
    queue_pixel(1023, 1023);
    queue_pixel(0, 1023);
    drain();

    // small soft brush: center, ring edge, corner beyond R, outside square
    set_brush(17'h1FC08, 17'd0);  // upper data bits ignored, R = 8
    queue_pixel(8, 8);
    queue_pixel(15, 8);
    queue_pixel(8, 0);
    queue_pixel(0, 0);
    queue_pixel(16, 8);
    queue_pixel(3, 15);
    drain();

    // full hardness, then hardness above 1.0
    set_brush(17'd8, sba_pkg::HARD_ONE);
    queue_pixel(8, 0);
    queue_pixel(3, 8);
    queue_pixel(2, 2);
    drain();
    set_brush(17'd8, 17'h1FFFF);
    queue_pixel(0, 8);
    queue_pixel(15, 15);
    drain();

    // radius above the limit saturates to 512
    set_brush(17'h003FF, 17'd32768);
    queue_pixel(0, 0);
    queue_pixel(1023, 1023);
    queue_pixel(512, 512);
    queue_pixel(0, 512);
    queue_pixel(1023, 0);
    drain();

    // radius one
    set_brush(17'd1, 17'd0);
    queue_pixel(0, 0);
    queue_pixel(1, 1);
    queue_pixel(0, 1);
    queue_pixel(2, 0);
    drain();

    while (queued_cnt < TOTAL_PIXELS) begin
      case ($urandom_range(0, 9))
        0: rad = 0;
        1: rad = $urandom_range(sba_pkg::MAX_RADIUS_DEF + 1, 1023);
        2: rad = $urandom_range(256, sba_pkg::MAX_RADIUS_DEF);
        3: rad = sba_pkg::MAX_RADIUS_DEF;
        default: rad = $urandom_range(1, 48);
      endcase
      case ($urandom_range(0, 5))
        0: hard = 0;
        1: hard = sba_pkg::HARD_ONE;
        2: hard = $urandom_range(sba_pkg::HARD_ONE + 1, 17'h1FFFF);
        default: hard = $urandom_range(0, sba_pkg::HARD_ONE);
      endcase
      set_brush({7'($urandom), 10'(rad)}, 17'(hard));
      calm = ($urandom_range(0, 3) == 0);
      reff = (rad > sba_pkg::MAX_RADIUS_DEF) ? sba_pkg::MAX_RADIUS_DEF : rad;
      npix = $urandom_range(20, 60);
      repeat (npix) begin
        if (reff != 0 && $urandom_range(0, 9) != 0)
          queue_pixel($urandom_range(0, 2 * reff - 1), $urandom_range(0, 2 * reff - 1));
        else
          queue_pixel($urandom_range(0, 1023), $urandom_range(0, 1023));
      end
      drain();
    end

    $display("Checked %0d alpha values over %0d brush settings", checked_cnt, phase_cnt);
    $display("(radius 0 to 1023, hardness 0 to 131071, random idle on both sides)");
    if (error_cnt == 0) begin
      $display("soft_brush_alpha_mask regression: pass");
    end else begin
      $display("soft_brush_alpha_mask regression: fail");
    end
    $finish;
  end

endmodule

// File: filelist.f
hw/rtl/sba_pkg.sv
hw/rtl/soft_brush_alpha_mask.sv
bench/soft_brush_alpha_mask_tb.sv
